@@ hw/rtl/hdm_pkg.sv @@
// Package for the table-matching Huffman decoder.
// Holds the field widths, the action and register index codes and the cell control struct.
// Used by every other file of the block.
`default_nettype none
package hdm_pkg;
	localparam int unsigned SYM_W   = 8;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned CODE_W  = 32;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 24;
	localparam int unsigned CCNT_W  = 9;
	localparam int unsigned CFG_W   = 24;
	localparam int unsigned CFGI_W  = 1;
	localparam int unsigned BIT_W   = 3;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	localparam logic [CFGI_W-1:0] CFG_CODE_COUNT    = 1'd0;
	localparam logic [CFGI_W-1:0] CFG_TOTAL_SYMBOLS = 1'd1;

	// Control broadcast to every cell for one bit step.
	typedef struct packed {
		logic step;
		logic restart;
		logic code_bit;
	} ctl_t;
endpackage
`default_nettype wire

@@ hw/rtl/hdm_if.sv @@
// Channel interfaces of the Huffman decoder: request in, symbol out.
// Depends on hdm_pkg for field widths.
`default_nettype none
interface hdm_in_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [hdm_pkg::IDX_W-1:0]    entry_index;
	logic [hdm_pkg::SYM_W-1:0]    entry_symbol;
	logic [hdm_pkg::LEN_W-1:0]    entry_length;
	logic [hdm_pkg::CODE_W-1:0]   entry_bits;
	logic [hdm_pkg::BYTE_W-1:0]   code_byte;
	modport source (output valid, action, entry_index, entry_symbol, entry_length,
		entry_bits, code_byte, input ready);
	modport sink (input valid, action, entry_index, entry_symbol, entry_length,
		entry_bits, code_byte, output ready);
endinterface

interface hdm_out_if;
	logic                       valid;
	logic                       ready;
	logic [hdm_pkg::SYM_W-1:0]  symbol;
	logic                       last_in_byte;
	logic                       all_done;
	modport source (output valid, symbol, last_in_byte, all_done, input ready);
	modport sink (input valid, symbol, last_in_byte, all_done, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/huffman_table_match_decoder.sv @@
// Huffman decoder by table matching: a row of entry cells fed by a bit sequencer.
// Depends on hdm_pkg, hdm_if and hdm_cell.
//
// A load request writes one table cell, and the block takes the next request in the
// following cycle. A decode request holds off the next request while it runs: the
// accepting cycle, a step per bit of the byte, least significant bit first, and a flush
// of its last symbol. It ends sooner once the symbol total is reached, and it takes
// longer while the symbol output is stalled. Every cell compares the bit in the same
// cycle; the first completing cell along the chain wins and all cells restart. The block
// takes one request at a time. There is no clearing pass: a slot that is decoded against
// must have been loaded first.
`default_nettype none
module huffman_table_match_decoder #(
	parameter int unsigned MAX_CODES    = 256,
	parameter int unsigned MAX_CODE_LEN = 32
) (
	input  wire                            clk,
	input  wire                            arst_n,
	hdm_in_if.sink                         item,
	hdm_out_if.source                      result,
	input  wire                            cfg_we,
	input  wire [hdm_pkg::CFGI_W-1:0]      cfg_index,
	input  wire [hdm_pkg::CFG_W-1:0]       cfg_data
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BIT   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]                    state_q;
	logic [hdm_pkg::BIT_W-1:0]     bit_idx_q;
	logic [hdm_pkg::BYTE_W-1:0]    byte_q;
	logic [hdm_pkg::CNT_W-1:0]     count_q;
	logic [hdm_pkg::CCNT_W-1:0]    code_count_q;
	logic [hdm_pkg::CNT_W-1:0]     total_q;
	logic                          pend_valid_q;
	logic [hdm_pkg::SYM_W-1:0]     pend_sym_q;
	logic                          pend_done_q;
	logic                          out_valid_q;
	logic [hdm_pkg::SYM_W-1:0]     out_sym_q;
	logic                          out_last_q;
	logic                          out_done_q;

	logic                          found_c [0:MAX_CODES];
	logic [hdm_pkg::SYM_W-1:0]     sym_c   [0:MAX_CODES];
	hdm_pkg::ctl_t                 ctl;
	logic                          out_free;
	logic                          out_load;
	logic                          emit;
	logic                          hit_total;
	logic                          accept;
	logic                          load_req;

	assign item.ready          = (state_q == ST_IDLE);
	assign accept              = item.valid && item.ready;
	assign load_req            = accept && (item.action == hdm_pkg::ACT_LOAD);
	assign result.valid        = out_valid_q;
	assign result.symbol       = out_sym_q;
	assign result.last_in_byte = out_last_q;
	assign result.all_done     = out_done_q;

	assign out_free  = !out_valid_q || result.ready;
	assign found_c[0] = 1'b0;
	assign sym_c[0]   = '0;
	assign emit      = ctl.step && found_c[MAX_CODES];
	assign hit_total = (count_q + hdm_pkg::CNT_W'(1)) == total_q;
	// The held symbol moves to the output when a newer one arrives or the byte ends.
	assign out_load  = pend_valid_q && (emit || ((state_q == ST_FLUSH) && out_free));

	always_comb begin
		ctl.step     = (state_q == ST_BIT) && out_free;
		ctl.code_bit = byte_q[bit_idx_q];
		ctl.restart  = found_c[MAX_CODES];
	end

	for (genvar j = 0; j < MAX_CODES; j++) begin : g_cell
		hdm_cell #(
			.MAX_CODE_LEN (MAX_CODE_LEN),
			.SLOT         (j)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.load_en    (load_req && (32'(item.entry_index) == 32'(j))),
			.load_sym   (item.entry_symbol),
			.load_len   (item.entry_length),
			.load_code  (item.entry_bits),
			.code_count (code_count_q),
			.ctl        (ctl),
			.found_in   (found_c[j]),
			.sym_in     (sym_c[j]),
			.found_out  (found_c[j+1]),
			.sym_out    (sym_c[j+1])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= item.code_byte;
		end
		if (emit) begin
			pend_sym_q  <= sym_c[MAX_CODES];
			pend_done_q <= hit_total;
		end
		if (emit && pend_valid_q) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= 1'b0;
			out_done_q <= pend_done_q;
		end else if ((state_q == ST_FLUSH) && out_free && pend_valid_q) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= 1'b1;
			out_done_q <= pend_done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bit_idx_q    <= '0;
			count_q      <= '0;
			code_count_q <= '0;
			total_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					hdm_pkg::CFG_CODE_COUNT: code_count_q <= hdm_pkg::CCNT_W'(cfg_data);
					hdm_pkg::CFG_TOTAL_SYMBOLS: total_q <= cfg_data;
					default: ;
				endcase
			end
			out_valid_q <= out_load || (out_valid_q && !result.ready);
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.action == hdm_pkg::ACT_DECODE) &&
						(count_q < total_q)) begin
						state_q   <= ST_BIT;
						bit_idx_q <= '0;
					end
				end
				ST_BIT: begin
					if (ctl.step) begin
						if (emit) begin
							count_q      <= count_q + hdm_pkg::CNT_W'(1);
							pend_valid_q <= 1'b1;
						end
						if ((emit && hit_total) || (bit_idx_q == hdm_pkg::BIT_W'(7))) begin
							state_q <= ST_FLUSH;
						end else begin
							bit_idx_q <= bit_idx_q + hdm_pkg::BIT_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						// The held symbol, if any, is the last one of this byte.
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/hdm_cell.sv @@
// One table entry of the decoder: code storage, match position and alive mark.
// Passes the first completed symbol down the chain. Depends on hdm_pkg.
`default_nettype none
module hdm_cell #(
	parameter int unsigned MAX_CODE_LEN = 32,
	parameter int unsigned SLOT         = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          load_en,
	input  wire [hdm_pkg::SYM_W-1:0]     load_sym,
	input  wire [hdm_pkg::LEN_W-1:0]     load_len,
	input  wire [hdm_pkg::CODE_W-1:0]    load_code,
	input  wire [hdm_pkg::CCNT_W-1:0]    code_count,
	input  hdm_pkg::ctl_t                ctl,
	input  wire                          found_in,
	input  wire [hdm_pkg::SYM_W-1:0]     sym_in,
	output logic                         found_out,
	output logic [hdm_pkg::SYM_W-1:0]    sym_out
);
	localparam int unsigned PW = $clog2(MAX_CODE_LEN + 1);
	localparam int unsigned XW = (PW > hdm_pkg::LEN_W) ? PW : hdm_pkg::LEN_W;
	localparam int unsigned SW = (hdm_pkg::CCNT_W > 32) ? hdm_pkg::CCNT_W : 32;

	logic [hdm_pkg::SYM_W-1:0]  sym_q;
	logic [hdm_pkg::LEN_W-1:0]  len_q;
	logic [hdm_pkg::CODE_W-1:0] code_q;
	logic [PW-1:0]              pos_q;
	logic                       alive_q;

	logic          active;
	logic          cbit;
	logic          mismatch;
	logic          complete;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] npos_x;

	always_comb begin
		active = SW'(code_count) > SW'(SLOT);
		pos_x  = XW'(pos_q);
		npos_x = pos_x + XW'(1);
		// Code bits past the stored word read as zero.
		cbit = (pos_x >= XW'(hdm_pkg::CODE_W)) ? 1'b0 : code_q[pos_x[4:0]];
		mismatch = (pos_x >= XW'(MAX_CODE_LEN)) || (cbit != ctl.code_bit);
		complete = active && alive_q && !mismatch && (npos_x == XW'(len_q));
		found_out = found_in || complete;
		sym_out = found_in ? sym_in : sym_q;
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			sym_q  <= load_sym;
			len_q  <= load_len;
			code_q <= load_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			alive_q <= 1'b1;
		end else if (ctl.step) begin
			if (ctl.restart) begin
				pos_q   <= '0;
				alive_q <= 1'b1;
			end else if (active && alive_q) begin
				if (mismatch) begin
					alive_q <= 1'b0;
				end else begin
					pos_q <= PW'(npos_x);
				end
			end
		end
	end
endmodule
`default_nettype wire
